// ===== rtl/core/lfga_pkg.sv =====
// lowest free gate allocator: shared constants, transaction types and the token
// that travels down the row of gate cells
// no dependencies
package lfga_pkg;

  localparam int GATES      = 16;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 20;
  localparam int TOTAL_BITS = 24;
  localparam int GATE_BITS  = 5;
  localparam int CFG_BITS   = 5;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX    = {TOTAL_BITS{1'b1}};
  localparam logic [CFG_BITS-1:0]   GATES_RESET  = CFG_BITS'(GATES);

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  // input transaction
  typedef struct packed {
    logic                  op;
    logic [TIME_BITS-1:0]  arrival;
    logic [TIME_BITS-1:0]  departure;
    logic [GATE_BITS-1:0]  query_gates;
  } lfga_in_t;

  // result transaction
  typedef struct packed {
    logic                  granted;
    logic [GATE_BITS-1:0]  gate;
    logic [TOTAL_BITS-1:0] total;
  } lfga_out_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  op;
    logic [TIME_BITS-1:0]  arrival;
    logic [TIME_BITS-1:0]  departure;
    logic [GATE_BITS-1:0]  left;   // cells still inside the grant or sum range
    logic [GATE_BITS-1:0]  pos;    // index of the cell the token enters
    logic                  found;
    logic [GATE_BITS-1:0]  gate;
    logic [TOTAL_BITS-1:0] total;
  } lfga_token_t;

endpackage

// ===== rtl/core/lfga_cell.sv =====
// one gate cell: holds busy flag, end time and use count of a single gate
// and passes the transaction token on to its neighbor through its token register
// depends on lfga_pkg
module lfga_cell import lfga_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lfga_token_t tok_in,
  output lfga_token_t tok_out
);

  logic                  busy;
  logic [TIME_BITS-1:0]  end_time;
  logic [COUNT_BITS-1:0] count;
  lfga_token_t           tok_q;
  lfga_token_t           tok_next;

  logic                  is_req;
  logic                  in_range;
  logic                  expired;
  logic                  claim;
  logic [TOTAL_BITS:0]   sum_wide;

  // freeing compare and claim decision
  assign is_req   = tok_in.valid && (tok_in.op == OP_REQUEST);
  assign in_range = (tok_in.left != '0);
  assign expired  = busy && (end_time <= tok_in.arrival);
  assign claim    = is_req && !tok_in.found && in_range && (!busy || expired);
  assign sum_wide = {1'b0, tok_in.total} + (TOTAL_BITS+1)'(count);

  // token update
  always_comb begin
    tok_next      = tok_in;
    tok_next.left = in_range ? tok_in.left - 1'b1 : '0;
    tok_next.pos  = tok_in.pos + 1'b1;
    if (claim) begin
      tok_next.found = 1'b1;
      tok_next.gate  = tok_in.pos + 1'b1;
    end
    if ((tok_in.op == OP_QUERY) && in_range) begin
      tok_next.total = sum_wide[TOTAL_BITS] ? TOTAL_MAX : sum_wide[TOTAL_BITS-1:0];
    end
  end

  // gate state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (claim) begin
      busy <= 1'b1;
      if (count != COUNT_MAX) begin
        count <= count + 1'b1;
      end
    end else if (is_req && expired) begin
      busy <= 1'b0;
    end
  end

  // end time has no reset, only read while busy
  always_ff @(posedge clk) begin
    if (claim) begin
      end_time <= tok_in.departure;
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q <= tok_next;
    end
  end

  assign tok_out = tok_q;

endmodule

// ===== rtl/core/lowest_free_gate_allocator_unit.sv =====
// top level of the lowest free gate allocator: config register, token
// launch, the row of gate cells and the result strobe
// depends on lfga_pkg and lfga_cell
//
// Each transaction enters a row of GATES cells, one cell per gate, and its
// token moves one cell per clock from the launch register through the cell
// registers to the result; busy drops in the cycle after done. Requests
// free expired gates in every cell and take the lowest free gate within
// gates_limit; queries sum use counts with saturation. The result is
// shown for exactly one cycle with done and cannot be held off. A new
// start is taken only while busy is low.
module lowest_free_gate_allocator_unit import lfga_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lfga_in_t            item,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  output logic                done,
  output lfga_out_t           result
);

  logic                gates_in_use;
  logic [CFG_BITS-1:0] gates_limit;
  logic                active;
  logic                accept;
  lfga_token_t         tok [GATES+1];
  logic [GATES:0]      tok_valid;

  assign accept = start && !active;
  assign busy   = active;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gates_limit <= GATES_RESET;
    end else if (cfg_we) begin
      gates_limit <= cfg_data;
    end
  end

  assign gates_in_use = (gates_limit != '0);

  // busy while a transaction is in the row
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      active <= 1'b1;
    end else if (done) begin
      active <= 1'b0;
    end
  end

  // launch token into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid     <= accept;
      tok[0].op        <= item.op;
      tok[0].arrival   <= item.arrival;
      tok[0].departure <= item.departure;
      tok[0].left      <= (item.op == OP_QUERY) ? item.query_gates : gates_limit;
      tok[0].pos       <= '0;
      tok[0].found     <= 1'b0;
      tok[0].gate      <= '0;
      tok[0].total     <= '0;
    end
  end

  // row of gate cells
  for (genvar g = 0; g < GATES; g++) begin : g_cell
    lfga_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  for (genvar g = 0; g <= GATES; g++) begin : g_valid
    assign tok_valid[g] = tok[g].valid;
  end

  // result from the last token register
  assign done           = tok[GATES].valid;
  assign result.granted = tok[GATES].found;
  assign result.gate    = tok[GATES].gate;
  assign result.total   = tok[GATES].total;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one transaction in the cell row");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe without an active transaction");

  a_grant_shape: assert property (@(posedge clk) disable iff (rst)
    done && result.granted |-> (result.gate != '0) && (result.total == '0))
    else $error("granted result with bad gate or total");

  a_no_grant_when_zero: assert property (@(posedge clk) disable iff (rst)
    accept && !gates_in_use && (item.op == OP_REQUEST) |=> !tok[0].found)
    else $error("request launched with a gate already found");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after start");
`endif

endmodule

// ===== tb/lowest_free_gate_allocator_unit_tb.sv =====
// testbench for the lowest free gate allocator: directed table, then random
// interval requests and queries checked against a behavioral allocator model
// depends on lfga_pkg and lowest_free_gate_allocator_unit
module lowest_free_gate_allocator_unit_tb;
  import lfga_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_ROWS  = 14;
  localparam int CFG_PHASES     = 10;
  localparam int PHASE_ITEMS    = 85;
  localparam int RANDOM_ITEMS   = CFG_PHASES * PHASE_ITEMS;
  localparam int MAX_GAP        = 30;
  localparam int DRAIN_CYCLES   = GATES + 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    lfga_in_t  stim;
    logic      has_typed;
    lfga_out_t typed;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  lfga_in_t            item;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_data;
  logic                done;
  lfga_out_t           result;

  // typed expectation travels with the transaction it belongs to
  logic                use_typed;
  lfga_out_t           typed_value;

  // allocator model state
  logic [CFG_BITS-1:0]   model_gates_in_use;
  logic                  model_busy [GATES];
  logic [TIME_BITS-1:0]  model_held_until [GATES];
  logic [COUNT_BITS-1:0] model_uses [GATES];

  lfga_out_t awaited_results [$];
  lfga_out_t oldest;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  lowest_free_gate_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lfga_in_t request(input logic [TIME_BITS-1:0] arr,
                                       input logic [TIME_BITS-1:0] dep);
    lfga_in_t r;
    r = '0;
    r.op = OP_REQUEST;
    r.arrival = arr;
    r.departure = dep;
    return r;
  endfunction

  function automatic lfga_in_t query(input logic [GATE_BITS-1:0] k);
    lfga_in_t r;
    r = '0;
    r.op = OP_QUERY;
    r.query_gates = k;
    return r;
  endfunction

  function automatic lfga_out_t outcome(input logic g, input int unsigned n,
                                        input int unsigned sum);
    lfga_out_t r;
    r.granted = g;
    r.gate = GATE_BITS'(n);
    r.total = TOTAL_BITS'(sum);
    return r;
  endfunction

  // grant the lowest free gate, or sum use counts for a query
  function automatic lfga_out_t allocate_or_sum(input lfga_in_t it);
    lfga_out_t           r;
    int                  span;
    logic                found;
    logic [TOTAL_BITS:0] acc;
    r = '0;
    if (it.op == OP_QUERY) begin
      span = (it.query_gates > GATES) ? GATES : int'(it.query_gates);
      acc = '0;
      for (int i = 0; i < span; i++) begin
        acc = acc + (TOTAL_BITS+1)'(model_uses[i]);
        if (acc > {1'b0, TOTAL_MAX}) acc = {1'b0, TOTAL_MAX};
      end
      r.total = acc[TOTAL_BITS-1:0];
    end else begin
      // free expired gates first
      for (int i = 0; i < GATES; i++) begin
        if (model_busy[i] && model_held_until[i] <= it.arrival) model_busy[i] = 1'b0;
      end
      span = (model_gates_in_use > GATES) ? GATES : int'(model_gates_in_use);
      found = 1'b0;
      for (int i = 0; i < span; i++) begin
        if (!found && !model_busy[i]) begin
          found = 1'b1;
          model_busy[i] = 1'b1;
          model_held_until[i] = it.departure;
          if (model_uses[i] != COUNT_MAX) model_uses[i] = model_uses[i] + 1'b1;
          r.granted = 1'b1;
          r.gate = GATE_BITS'(i + 1);
        end
      end
    end
    return r;
  endfunction

  // model update, result check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      model_gates_in_use = GATES_RESET;
      for (int i = 0; i < GATES; i++) begin
        model_busy[i] = 1'b0;
        model_held_until[i] = '0;
        model_uses[i] = '0;
      end
      awaited_results.delete();
    end else begin
      if (cfg_we) model_gates_in_use = cfg_data;
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: granted %0d gate %0d total %0d",
                 result.granted, result.gate, result.total);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (result.granted !== oldest.granted) begin
            $error("granted: expected %0d, actual %0d", oldest.granted, result.granted);
            mismatches++;
          end
          if (result.gate !== oldest.gate) begin
            $error("gate: expected %0d, actual %0d", oldest.gate, result.gate);
            mismatches++;
          end
          if (result.total !== oldest.total) begin
            $error("total: expected %0d, actual %0d", oldest.total, result.total);
            mismatches++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        oldest = allocate_or_sum(item);
        awaited_results.push_back(use_typed ? typed_value : oldest);
      end
    end
    if ((start && busy === 1'b0) || done || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // hold one transaction on the inputs until the block takes it
  task automatic issue(input lfga_in_t it, input logic has_typed, input lfga_out_t typed);
    start <= 1'b1;
    item <= it;
    use_typed <= has_typed;
    typed_value <= typed;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // random sender gap after an accepted transaction
  task automatic pace_sender(input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  initial begin
    directed_row_t         rows [DIRECTED_ROWS];
    logic [CFG_BITS-1:0]   phase_cfg [CFG_PHASES];
    lfga_in_t              it;
    logic [TIME_BITS-1:0]  now_ts;
    int                    idle_pct;
    int                    n;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    use_typed = 1'b0;
    typed_value = '0;

    // directed transactions with the reset setting of 16 gates
    rows = '{
      '{query(5'd16), 1'b1, outcome(1'b0, 0, 0)},               // empty after reset
      '{request(32'd0, 32'd10), 1'b1, outcome(1'b1, 1, 0)},
      '{request(32'd0, 32'hFFFF_FFFF), 1'b1, outcome(1'b1, 2, 0)},
      '{request(32'd5, 32'd3), 1'b1, outcome(1'b1, 3, 0)},      // departure before arrival
      '{query(5'd31), 1'b1, outcome(1'b0, 0, 3)},               // query range above gate count
      '{query(5'd0), 1'b1, outcome(1'b0, 0, 0)},
      '{request(32'd10, 32'd20), 1'b1, outcome(1'b1, 1, 0)},    // frees at equal end time
      '{request(32'd4, 32'd8), 1'b0, '0},                       // arrival out of order
      '{query(5'd1), 1'b1, outcome(1'b0, 0, 2)},
      '{request(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0},
      '{request(32'hFFFF_FFFF, 32'd0), 1'b0, '0},
      '{request(32'h8000_0000, 32'hFFFF_FFFF), 1'b0, '0},
      '{query(5'd17), 1'b0, '0},
      '{query(5'd16), 1'b0, '0}
    };
    phase_cfg = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'($urandom_range(0, 31)),
                  5'd17, 5'd8, 5'd15};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      issue(rows[r].stim, rows[r].has_typed, rows[r].typed);
      pace_sender(23);
    end

    now_ts = 32'd100;
    n = 0;
    for (int p = 0; p < CFG_PHASES; p++) begin
      // change the setting only once the block has drained
      start <= 1'b0;
      use_typed <= 1'b0;
      @(posedge clk);
      while (awaited_results.size() != 0 || busy !== 1'b0) @(posedge clk);
      repeat (2) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_data <= phase_cfg[p];
      @(posedge clk);
      cfg_we <= 1'b0;

      for (int j = 0; j < PHASE_ITEMS; j++) begin
        idle_pct = (n < RANDOM_ITEMS / 3) ? 23 : (n < 2 * RANDOM_ITEMS / 3) ? 77 : 0;
        it.op = ($urandom_range(0, 99) < 20) ? OP_QUERY : OP_REQUEST;
        it.query_gates = GATE_BITS'($urandom_range(0, 31));
        if (it.op == OP_QUERY || $urandom_range(0, 99) < 15) begin
          // noise, or fields that a query ignores
          it.arrival = $urandom;
          it.departure = $urandom;
        end else begin
          // well-formed interval in arrival order
          if ($urandom_range(0, 99) < 3) now_ts = $urandom;
          else now_ts = now_ts + TIME_BITS'($urandom_range(0, 6));
          it.arrival = now_ts;
          if ($urandom_range(0, 99) < 5) it.departure = now_ts;
          else it.departure = now_ts + TIME_BITS'($urandom_range(1, 90));
        end
        issue(it, 1'b0, '0);
        pace_sender(idle_pct);
        n++;
      end
    end

    // drain and let the block settle
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
